@@ rtl/dcc_pkg.sv @@
// Shared constants for the dominant channel color correction pipeline.
`timescale 1ns / 1ps
package dcc_pkg;
  localparam int RegW       = 16;
  localparam int StrengthW  = 16;
  localparam int RatioFrac  = 16;
  localparam logic [RatioFrac:0] RatioOne = 17'(1) << RatioFrac;
  localparam logic [RatioFrac:0] RatioMin = 17'd13107;
  localparam int FrontLat   = 4;
  localparam int ScaleLat   = 3;
  localparam int TotalLat   = FrontLat + RatioFrac + ScaleLat + 1;

  localparam logic [1:0] DOM_RED   = 2'd0;
  localparam logic [1:0] DOM_GREEN = 2'd1;
  localparam logic [1:0] DOM_BLUE  = 2'd2;

  localparam logic [1:0] CFG_SKY_RED   = 2'd0;
  localparam logic [1:0] CFG_SKY_GREEN = 2'd1;
  localparam logic [1:0] CFG_SKY_BLUE  = 2'd2;
  localparam logic [1:0] CFG_REF_FLOOR = 2'd3;

  typedef struct packed {
    logic [RegW-1:0] sky_red;
    logic [RegW-1:0] sky_green;
    logic [RegW-1:0] sky_blue;
    logic [RegW-1:0] ref_floor;
  } cfg_t;
endpackage

@@ rtl/dcc_front.sv @@
// Front stages: input capture, sky subtraction, dominant pick, ratio products.
`timescale 1ns / 1ps
module dcc_front #(
  parameter int S  = 16,
  parameter int RW = 16,
  parameter int NW = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  dcc_pkg::cfg_t                  cfg_i,
  input  logic [S-1:0]                   red_i,
  input  logic [S-1:0]                   green_i,
  input  logic [S-1:0]                   blue_i,
  input  logic [S-1:0]                   ref_red_i,
  input  logic [S-1:0]                   ref_green_i,
  input  logic [S-1:0]                   ref_blue_i,
  input  logic [dcc_pkg::StrengthW-1:0]  strength_i,
  output logic                           valid_o,
  output logic [NW-1:0]                  num0_o,
  output logic [NW-1:0]                  den0_o,
  output logic                           sat0_o,
  output logic [S-1:0]                   x0_o,
  output logic [NW-1:0]                  num1_o,
  output logic [NW-1:0]                  den1_o,
  output logic                           sat1_o,
  output logic [S-1:0]                   x1_o,
  output logic [dcc_pkg::StrengthW-1:0]  strength_o,
  output logic [1:0]                     dom_o,
  output logic [S-1:0]                   dval_o
);
  // stage 1: captured inputs
  logic v1_q;
  logic [S-1:0] r1_q, g1_q, b1_q, rr1_q, rg1_q, rb1_q;
  logic [dcc_pkg::StrengthW-1:0] s1_q;
  // stage 2: lane selection
  logic v2_q;
  logic [1:0] dom2_q, dom2_d;
  logic [S-1:0] dv2_q, dv2_d, x02_q, x02_d, x12_q, x12_d;
  logic [RW-1:0] rd2_q, rd2_d, rx02_q, rx02_d, rx12_q, rx12_d;
  logic [dcc_pkg::StrengthW-1:0] s2_q;
  // stage 3: products
  logic v3_q;
  logic [NW-1:0] n03_q, d03_q, n13_q, d13_q;
  logic [S-1:0] x03_q, x13_q, dv3_q;
  logic [1:0] dom3_q;
  logic [dcc_pkg::StrengthW-1:0] s3_q;
  // stage 4: saturation flags
  logic v4_q;

  function automatic logic [RW-1:0] sky_sub(input logic [S-1:0] ref_v,
                                            input logic [dcc_pkg::RegW-1:0] sky,
                                            input logic [dcc_pkg::RegW-1:0] flr);
    logic signed [RW:0] diff;
    logic signed [RW:0] flr_s;
    diff  = signed'({1'b0, RW'(ref_v)}) - signed'({1'b0, RW'(sky)});
    flr_s = signed'({1'b0, RW'(flr)});
    return (diff < flr_s) ? RW'(flr) : diff[RW-1:0];
  endfunction

  logic [RW-1:0] rr_s, rg_s, rb_s;

  always_comb begin
    rr_s = sky_sub(rr1_q, cfg_i.sky_red, cfg_i.ref_floor);
    rg_s = sky_sub(rg1_q, cfg_i.sky_green, cfg_i.ref_floor);
    rb_s = sky_sub(rb1_q, cfg_i.sky_blue, cfg_i.ref_floor);
    // ties go to red, then green
    priority if (r1_q >= g1_q && r1_q >= b1_q) begin
      dom2_d = dcc_pkg::DOM_RED;
      dv2_d  = r1_q;  rd2_d  = rr_s;
      x02_d  = g1_q;  rx02_d = rg_s;
      x12_d  = b1_q;  rx12_d = rb_s;
    end else if (g1_q > r1_q && g1_q >= b1_q) begin
      dom2_d = dcc_pkg::DOM_GREEN;
      dv2_d  = g1_q;  rd2_d  = rg_s;
      x02_d  = r1_q;  rx02_d = rr_s;
      x12_d  = b1_q;  rx12_d = rb_s;
    end else begin
      dom2_d = dcc_pkg::DOM_BLUE;
      dv2_d  = b1_q;  rd2_d  = rb_s;
      x02_d  = r1_q;  rx02_d = rr_s;
      x12_d  = g1_q;  rx12_d = rg_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q  <= red_i;
    g1_q  <= green_i;
    b1_q  <= blue_i;
    rr1_q <= ref_red_i;
    rg1_q <= ref_green_i;
    rb1_q <= ref_blue_i;
    s1_q  <= strength_i;

    dom2_q <= dom2_d;
    dv2_q  <= dv2_d;
    x02_q  <= x02_d;
    x12_q  <= x12_d;
    rd2_q  <= rd2_d;
    rx02_q <= rx02_d;
    rx12_q <= rx12_d;
    s2_q   <= s1_q;

    n03_q  <= NW'(rx02_q * dv2_q);
    d03_q  <= NW'(rd2_q * x02_q);
    n13_q  <= NW'(rx12_q * dv2_q);
    d13_q  <= NW'(rd2_q * x12_q);
    x03_q  <= x02_q;
    x13_q  <= x12_q;
    dv3_q  <= dv2_q;
    dom3_q <= dom2_q;
    s3_q   <= s2_q;

    num0_o     <= n03_q;
    den0_o     <= d03_q;
    sat0_o     <= (d03_q == '0) || (n03_q >= d03_q);
    num1_o     <= n13_q;
    den1_o     <= d13_q;
    sat1_o     <= (d13_q == '0) || (n13_q >= d13_q);
    x0_o       <= x03_q;
    x1_o       <= x13_q;
    dval_o     <= dv3_q;
    dom_o      <= dom3_q;
    strength_o <= s3_q;
  end

  assign valid_o = v4_q;
endmodule

@@ rtl/dcc_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
module dcc_div #(
  parameter int NW     = 32,
  parameter int SIDE_W = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [NW-1:0]                  num_i,
  input  logic [NW-1:0]                  den_i,
  input  logic                           sat_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic [dcc_pkg::RatioFrac-1:0]  quo_o,
  output logic                           sat_o,
  output logic [SIDE_W-1:0]              side_o
);
  localparam int Steps = dcc_pkg::RatioFrac;

  logic [NW-1:0]     rem_q  [1:Steps];
  logic [NW-1:0]     den_q  [1:Steps];
  logic [Steps-1:0]  quo_q  [1:Steps];
  logic              sat_q  [1:Steps];
  logic [SIDE_W-1:0] side_q [1:Steps];
  logic              vld_q  [1:Steps];

  logic [NW-1:0]     rem_c  [0:Steps-1];
  logic [NW-1:0]     den_c  [0:Steps-1];
  logic [Steps-1:0]  quo_c  [0:Steps-1];
  logic [NW-1:0]     rem_d  [0:Steps-1];
  logic [Steps-1:0]  quo_d  [0:Steps-1];

  always_comb begin
    logic [NW:0] trial;
    logic [NW:0] den_x;
    logic        ge;
    rem_c[0] = num_i;
    den_c[0] = den_i;
    quo_c[0] = '0;
    for (int k = 1; k < Steps; k++) begin
      rem_c[k] = rem_q[k];
      den_c[k] = den_q[k];
      quo_c[k] = quo_q[k];
    end
    for (int k = 0; k < Steps; k++) begin
      trial    = {rem_c[k], 1'b0};
      den_x    = {1'b0, den_c[k]};
      ge       = (trial >= den_x);
      rem_d[k] = ge ? NW'(trial - den_x) : trial[NW-1:0];
      quo_d[k] = {quo_c[k][Steps-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= Steps; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[1] <= valid_i;
      for (int k = 2; k <= Steps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q[1]  <= sat_i;
    side_q[1] <= side_i;
    for (int k = 2; k <= Steps; k++) begin
      sat_q[k]  <= sat_q[k-1];
      side_q[k] <= side_q[k-1];
    end
    for (int k = 0; k < Steps; k++) begin
      rem_q[k+1] <= rem_d[k];
      den_q[k+1] <= den_c[k];
      quo_q[k+1] <= quo_d[k];
    end
  end

  assign valid_o = vld_q[Steps];
  assign quo_o   = quo_q[Steps];
  assign sat_o   = sat_q[Steps];
  assign side_o  = side_q[Steps];
endmodule

@@ rtl/dcc_scale.sv @@
// Ratio clamp, strength weighting and sample scaling for one channel.
`timescale 1ns / 1ps
module dcc_scale #(
  parameter int S      = 16,
  parameter int F      = 12,
  parameter int SIDE_W = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [dcc_pkg::RatioFrac-1:0]  quo_i,
  input  logic                           sat_i,
  input  logic [S-1:0]                   x_i,
  input  logic [dcc_pkg::StrengthW-1:0]  strength_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic [S-1:0]                   x_o,
  output logic [SIDE_W-1:0]              side_o
);
  localparam int SF = dcc_pkg::RatioFrac + F;
  localparam int PW = (SF + 1 > dcc_pkg::RatioFrac + 1 + dcc_pkg::StrengthW)
                      ? SF + 1 : dcc_pkg::RatioFrac + 1 + dcc_pkg::StrengthW;
  localparam logic [PW-1:0] ScaleOne = PW'(1) << SF;

  logic [dcc_pkg::RatioFrac:0] ratio;
  logic [PW-1:0]     prod_q;
  logic [SF:0]       scale_q;
  logic [S+SF:0]     mul_q;
  logic [S-1:0]      xa_q, xb_q;
  logic [SIDE_W-1:0] sa_q, sb_q, sc_q;
  logic              va_q, vb_q, vc_q;

  always_comb begin
    if (sat_i) begin
      ratio = dcc_pkg::RatioOne;
    end else if ({1'b0, quo_i} < dcc_pkg::RatioMin) begin
      ratio = dcc_pkg::RatioMin;
    end else begin
      ratio = {1'b0, quo_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= PW'((dcc_pkg::RatioOne - ratio) * strength_i);
    xa_q    <= x_i;
    sa_q    <= side_i;
    // a weight at or past one drives the channel to zero
    scale_q <= (prod_q >= ScaleOne) ? '0 : (SF+1)'(ScaleOne - prod_q);
    xb_q    <= xa_q;
    sb_q    <= sa_q;
    mul_q   <= (S+SF+1)'(xb_q * scale_q);
    sc_q    <= sb_q;
  end

  assign valid_o = vc_q;
  assign x_o     = mul_q[SF+S-1:SF];
  assign side_o  = sc_q;
endmodule

@@ rtl/dominant_channel_color_correction_core.sv @@
// Top level of the dominant channel color correction pipeline.
//
// channel   ports                                          handshake
// -------   ---------------------------------------------  -----------------------
// pixel in  red_in_i .. blue_in_i, ref_*_i, strength_i      start_i & !busy_o
// result    red_out_o, green_out_o, blue_out_o, dominant_o  valid_o, one cycle
// config    cfg_idx_i, cfg_wdata_i                          cfg_we_i
//
// One item per cycle while busy_o is low; each result follows its item through
// the 4 front stages, 16 divider stages at one quotient bit each, 3 scale
// stages and one output register. busy_o is high in reset and for the first
// cycle after it. The pipeline always advances; the receiver cannot stall,
// so no skid is kept.
`timescale 1ns / 1ps
module dominant_channel_color_correction_core #(
  parameter int SAMPLE_BITS      = 16,
  parameter int FACTOR_FRAC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [SAMPLE_BITS-1:0]        red_in_i,
  input  logic [SAMPLE_BITS-1:0]        green_in_i,
  input  logic [SAMPLE_BITS-1:0]        blue_in_i,
  input  logic [SAMPLE_BITS-1:0]        ref_red_i,
  input  logic [SAMPLE_BITS-1:0]        ref_green_i,
  input  logic [SAMPLE_BITS-1:0]        ref_blue_i,
  input  logic [dcc_pkg::StrengthW-1:0] strength_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [dcc_pkg::RegW-1:0]      cfg_wdata_i,
  output logic                          valid_o,
  output logic [SAMPLE_BITS-1:0]        red_out_o,
  output logic [SAMPLE_BITS-1:0]        green_out_o,
  output logic [SAMPLE_BITS-1:0]        blue_out_o,
  output logic [1:0]                    dominant_o
);
  localparam int S   = SAMPLE_BITS;
  localparam int RW  = (S > dcc_pkg::RegW) ? S : dcc_pkg::RegW;
  localparam int NW  = RW + S;
  localparam int SW  = dcc_pkg::StrengthW;
  localparam int Side0W = SW + 2 + S + S;
  localparam int Side1W = SW + S;

  dcc_pkg::cfg_t cfg_q;
  logic busy_q;
  logic accept;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b1;
      cfg_q.sky_red   <= 16'd4096;
      cfg_q.sky_green <= 16'd4096;
      cfg_q.sky_blue  <= 16'd4096;
      cfg_q.ref_floor <= 16'd10;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dcc_pkg::CFG_SKY_RED:   cfg_q.sky_red   <= cfg_wdata_i;
          dcc_pkg::CFG_SKY_GREEN: cfg_q.sky_green <= cfg_wdata_i;
          dcc_pkg::CFG_SKY_BLUE:  cfg_q.sky_blue  <= cfg_wdata_i;
          dcc_pkg::CFG_REF_FLOOR: cfg_q.ref_floor <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  logic          f_valid, f_sat0, f_sat1;
  logic [NW-1:0] f_num0, f_den0, f_num1, f_den1;
  logic [S-1:0]  f_x0, f_x1, f_dval;
  logic [SW-1:0] f_str;
  logic [1:0]    f_dom;

  dcc_front #(.S(S), .RW(RW), .NW(NW)) u_front (
    .clk_i, .rst_ni,
    .valid_i     (accept),
    .cfg_i       (cfg_q),
    .red_i       (red_in_i),
    .green_i     (green_in_i),
    .blue_i      (blue_in_i),
    .ref_red_i   (ref_red_i),
    .ref_green_i (ref_green_i),
    .ref_blue_i  (ref_blue_i),
    .strength_i  (strength_i),
    .valid_o     (f_valid),
    .num0_o      (f_num0),
    .den0_o      (f_den0),
    .sat0_o      (f_sat0),
    .x0_o        (f_x0),
    .num1_o      (f_num1),
    .den1_o      (f_den1),
    .sat1_o      (f_sat1),
    .x1_o        (f_x1),
    .strength_o  (f_str),
    .dom_o       (f_dom),
    .dval_o      (f_dval)
  );

  logic                          d_valid, d_sat0, d_sat1;
  logic [dcc_pkg::RatioFrac-1:0] d_quo0, d_quo1;
  logic [Side0W-1:0]             d_side0;
  logic [Side1W-1:0]             d_side1;

  dcc_div #(.NW(NW), .SIDE_W(Side0W)) u_div0 (
    .clk_i, .rst_ni,
    .valid_i (f_valid),
    .num_i   (f_num0),
    .den_i   (f_den0),
    .sat_i   (f_sat0),
    .side_i  ({f_str, f_dom, f_dval, f_x0}),
    .valid_o (d_valid),
    .quo_o   (d_quo0),
    .sat_o   (d_sat0),
    .side_o  (d_side0)
  );

  dcc_div #(.NW(NW), .SIDE_W(Side1W)) u_div1 (
    .clk_i, .rst_ni,
    .valid_i (f_valid),
    .num_i   (f_num1),
    .den_i   (f_den1),
    .sat_i   (f_sat1),
    .side_i  ({f_str, f_x1}),
    .valid_o (),
    .quo_o   (d_quo1),
    .sat_o   (d_sat1),
    .side_o  (d_side1)
  );

  logic          s_valid;
  logic [S-1:0]  s_x0, s_x1;
  logic [S+1:0]  s_side0;

  dcc_scale #(.S(S), .F(FACTOR_FRAC_BITS), .SIDE_W(S + 2)) u_scale0 (
    .clk_i, .rst_ni,
    .valid_i    (d_valid),
    .quo_i      (d_quo0),
    .sat_i      (d_sat0),
    .x_i        (d_side0[S-1:0]),
    .strength_i (d_side0[Side0W-1 -: SW]),
    .side_i     (d_side0[2*S+1:S]),
    .valid_o    (s_valid),
    .x_o        (s_x0),
    .side_o     (s_side0)
  );

  dcc_scale #(.S(S), .F(FACTOR_FRAC_BITS), .SIDE_W(1)) u_scale1 (
    .clk_i, .rst_ni,
    .valid_i    (d_valid),
    .quo_i      (d_quo1),
    .sat_i      (d_sat1),
    .x_i        (d_side1[S-1:0]),
    .strength_i (d_side1[Side1W-1 -: SW]),
    .side_i     (1'b0),
    .valid_o    (),
    .x_o        (s_x1),
    .side_o     ()
  );

  logic [1:0]   s_dom;
  logic [S-1:0] s_dval;
  logic         out_v_q;
  logic [S-1:0] red_q, green_q, blue_q;
  logic [1:0]   dom_q;

  assign s_dom  = s_side0[S+1:S];
  assign s_dval = s_side0[S-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= s_valid;
    end
  end

  // place the dominant sample back in its own channel
  always_ff @(posedge clk_i) begin
    dom_q <= s_dom;
    unique case (s_dom)
      dcc_pkg::DOM_RED: begin
        red_q <= s_dval; green_q <= s_x0; blue_q <= s_x1;
      end
      dcc_pkg::DOM_GREEN: begin
        red_q <= s_x0; green_q <= s_dval; blue_q <= s_x1;
      end
      default: begin
        red_q <= s_x0; green_q <= s_x1; blue_q <= s_dval;
      end
    endcase
  end

  assign valid_o     = out_v_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign dominant_o  = dom_q;

  a_dom_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (dominant_o != 2'd3))
    else $error("dominant code out of range");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(dcc_pkg::TotalLat) valid_o)
    else $error("result strobe does not match accepted item");

  a_red_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && dominant_o == dcc_pkg::DOM_RED) |->
      (red_out_o == $past(red_in_i, dcc_pkg::TotalLat)))
    else $error("dominant red sample altered");
endmodule
